[hw/rtl/btba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btba_pkg
// Types and fixed constants of the boundary tag block allocator.
// ----------------------------------------------------------------------------
package btba_pkg;

  // Width of a slot index stored in a header link (log2 of largest arena / 8).
  localparam int unsigned SLOT_W = 13;

  // Header size and the smallest payload of a block, in bytes.
  localparam logic [4:0] HDR_BYTES   = 5'd8;
  localparam logic [4:0] MIN_PAYLOAD = 5'd16;

  // Action codes on the input channel.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // One block header, one per 8-byte slot of the arena.
  typedef struct packed {
    logic              bfree;
    logic [15:0]       bsize;
    logic              free;
    logic [15:0]       size;
    logic              has_next;
    logic [SLOT_W-1:0] next;
    logic              has_prev;
    logic [SLOT_W-1:0] prev;
  } hdr_t;

endpackage

[hw/rtl/boundary_tag_block_allocator_unit.sv]
`timescale 1ns / 1ps
// Flow: one transfer at a time; a waiting result holds the sequencer in its
// final state, and the next transfer is accepted in the cycle after the result loads.
// Reset: the list holds one block at offset 0; slot 0 and the end slot read as reset headers.
// ----------------------------------------------------------------------------
// boundary_tag_block_allocator_unit
// First-fit heap allocator with boundary tags and an explicit free list,
// run by a sequencer over one synchronous header memory.
// ----------------------------------------------------------------------------
module boundary_tag_block_allocator_unit #(
  // Arena size in bytes; a power of two.
  parameter int unsigned ARENA_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] block_offset_o,
  output logic        ok_o
);
  import btba_pkg::*;

  localparam int unsigned NSLOTS = ARENA_BYTES / 8;
  localparam int unsigned IDX_W  = $clog2(NSLOTS);
  localparam int unsigned OFF_W  = IDX_W + 3;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NSLOTS - 1);
  localparam logic [15:0] BODY = 16'(ARENA_BYTES - 16);
  localparam logic [16:0] ARENA17 = 17'(ARENA_BYTES);
  localparam logic [16:0] SENT17  = 17'(ARENA_BYTES - 8);

  // Sequencer states. R states issue a read, D states use the data and some write it back.
  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_FIN   = 6'd1;
  localparam logic [5:0] S_W_R   = 6'd2;
  localparam logic [5:0] S_W_D   = 6'd3;
  localparam logic [5:0] S_SP_R  = 6'd4;
  localparam logic [5:0] S_SP_D  = 6'd5;
  localparam logic [5:0] S_SU_R  = 6'd6;
  localparam logic [5:0] S_SU_D  = 6'd7;
  localparam logic [5:0] S_CF_R  = 6'd8;
  localparam logic [5:0] S_CF_D  = 6'd9;
  localparam logic [5:0] S_CU_R  = 6'd10;
  localparam logic [5:0] S_CU_D  = 6'd11;
  localparam logic [5:0] S_UL_R  = 6'd12;
  localparam logic [5:0] S_UL_D  = 6'd13;
  localparam logic [5:0] S_UN_R  = 6'd14;
  localparam logic [5:0] S_UN_D  = 6'd15;
  localparam logic [5:0] S_UPV   = 6'd16;
  localparam logic [5:0] S_UP_R  = 6'd17;
  localparam logic [5:0] S_UP_D  = 6'd18;
  localparam logic [5:0] S_PS_R  = 6'd19;
  localparam logic [5:0] S_PS_D  = 6'd20;
  localparam logic [5:0] S_PH_R  = 6'd21;
  localparam logic [5:0] S_PH_D  = 6'd22;
  localparam logic [5:0] S_F0_R  = 6'd23;
  localparam logic [5:0] S_F0_D  = 6'd24;
  localparam logic [5:0] S_FL1_R = 6'd25;
  localparam logic [5:0] S_FL1_D = 6'd26;
  localparam logic [5:0] S_FL2_R = 6'd27;
  localparam logic [5:0] S_FL2_D = 6'd28;
  localparam logic [5:0] S_FL3_R = 6'd29;
  localparam logic [5:0] S_FL3_D = 6'd30;
  localparam logic [5:0] S_FL4_R = 6'd31;
  localparam logic [5:0] S_FL4_D = 6'd32;
  localparam logic [5:0] S_FU_R  = 6'd33;
  localparam logic [5:0] S_FU_D  = 6'd34;
  localparam logic [5:0] S_FM1_R = 6'd35;
  localparam logic [5:0] S_FM1_D = 6'd36;
  localparam logic [5:0] S_FM2_R = 6'd37;
  localparam logic [5:0] S_FM2_D = 6'd38;
  localparam logic [5:0] S_FM3_R = 6'd39;
  localparam logic [5:0] S_FM3_D = 6'd40;
  localparam logic [5:0] S_FM4_R = 6'd41;
  localparam logic [5:0] S_FM4_D = 6'd42;
  localparam logic [5:0] S_FB_R  = 6'd43;
  localparam logic [5:0] S_FB_D  = 6'd44;
  localparam logic [5:0] S_FB2_R = 6'd45;
  localparam logic [5:0] S_FB2_D = 6'd46;

  // Offset arithmetic wraps modulo the arena size.
  function automatic logic [OFF_W-1:0] wrap(input logic [16:0] x);
    return x[OFF_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_of(input logic [OFF_W-1:0] off);
    return off[OFF_W-1:3];
  endfunction

  function automatic logic [OFF_W-1:0] off_of(input logic [SLOT_W-1:0] s);
    return {s[IDX_W-1:0], 3'b000};
  endfunction

  // Upper neighbor of a block: offset + header + size.
  function automatic logic [OFF_W-1:0] upper(input logic [OFF_W-1:0] off,
                                             input logic [15:0] sz);
    return wrap(17'(off) + 17'(sz) + 17'(HDR_BYTES));
  endfunction

  // Header memory.
  hdr_t mem_q [NSLOTS];
  hdr_t mem_rd_q;
  logic [IDX_W-1:0] rd_slot_q;

  // Control registers.
  logic [5:0] state_q, state_d;
  logic [5:0] ret_q, ret_d;
  logic       hv_q, hv_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic       init0_q, initl_q;
  logic       out_valid_q, out_valid_d;

  // Working registers.
  logic [16:0]      size_q, size_d;
  logic [OFF_W-1:0] cur_q, cur_d;
  logic [OFF_W-1:0] nb_q, nb_d;
  logic [OFF_W-1:0] lo_q, lo_d;
  logic [15:0]      rest_q, rest_d;
  logic [15:0]      tmp_q, tmp_d;
  logic             cfree_q, cfree_d;
  logic [IDX_W:0]   steps_q, steps_d;
  logic [IDX_W-1:0] ul_q, ul_d;
  logic [IDX_W-1:0] ps_q, ps_d;
  logic             un_has_q, un_has_d;
  logic [IDX_W-1:0] un_q, un_d;
  logic             up_has_q, up_has_d;
  logic [IDX_W-1:0] upr_q, upr_d;
  logic             res_ok_q, res_ok_d;
  logic [15:0]      res_off_q, res_off_d;
  logic [15:0]      out_off_q, out_off_d;
  logic             out_ok_q, out_ok_d;

  logic             rd_en;
  logic [IDX_W-1:0] rd_slot;
  logic             wr_en;
  hdr_t             wr_data;
  hdr_t             rdat;

  // Raised and rounded request, and the free address checks.
  logic [16:0] req_min;
  logic [16:0] req_size;
  logic [15:0] blk_in;
  logic        free_bad;

  assign req_min  = (request_size_i < 16'(MIN_PAYLOAD)) ? 17'(MIN_PAYLOAD)
                                                        : 17'(request_size_i);
  assign req_size = (req_min + 17'd7) & ~17'd7;
  assign blk_in   = address_i - 16'(HDR_BYTES);
  assign free_bad = (address_i[2:0] != 3'd0) || (address_i < 16'(HDR_BYTES)) ||
                    (17'(address_i) >= ARENA17) || (17'(blk_in) >= SENT17);

  // Read data, with slot 0 and the end slot shown at their reset headers.
  always_comb begin
    rdat = mem_rd_q;
    if (init0_q && rd_slot_q == '0) begin
      rdat = '0;
      rdat.free = 1'b1;
      rdat.size = BODY;
    end else if (initl_q && rd_slot_q == LAST_SLOT) begin
      rdat = '0;
      rdat.bfree = 1'b1;
      rdat.bsize = BODY;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    hv_d      = hv_q;
    head_d    = head_q;
    size_d    = size_q;
    cur_d     = cur_q;
    nb_d      = nb_q;
    lo_d      = lo_q;
    rest_d    = rest_q;
    tmp_d     = tmp_q;
    cfree_d   = cfree_q;
    steps_d   = steps_q;
    ul_d      = ul_q;
    ps_d      = ps_q;
    un_has_d  = un_has_q;
    un_d      = un_q;
    up_has_d  = up_has_q;
    upr_d     = upr_q;
    res_ok_d  = res_ok_q;
    res_off_d = res_off_q;
    rd_en     = 1'b0;
    rd_slot   = slot_of(cur_q);
    wr_en     = 1'b0;
    wr_data   = rdat;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_ok_d  = 1'b0;
          res_off_d = '0;
          steps_d   = '0;
          if (action_i == ACT_ALLOC) begin
            size_d = req_size;
            cur_d  = off_of(SLOT_W'(head_q));
            if (request_size_i == '0 || !hv_q) begin
              state_d = S_FIN;
            end else begin
              state_d = S_W_R;
            end
          end else begin
            cur_d = blk_in[OFF_W-1:0];
            if (free_bad) begin
              state_d = S_FIN;
            end else begin
              state_d = S_F0_R;
            end
          end
        end
      end

      // First-fit walk over the free list.
      S_W_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(cur_q);
        state_d = S_W_D;
      end
      S_W_D: begin
        if ({1'b0, rdat.size} < size_q) begin
          if (!rdat.has_next || (steps_q + 1'b1) >= (IDX_W+1)'(NSLOTS)) begin
            state_d = S_FIN;
          end else begin
            steps_d = steps_q + 1'b1;
            cur_d   = off_of(rdat.next);
            state_d = S_W_R;
          end
        end else begin
          res_ok_d  = 1'b1;
          res_off_d = 16'(17'(cur_q) + 17'(HDR_BYTES));
          if ({2'b0, rdat.size} >= {1'b0, size_q} + 18'd24) begin
            wr_en        = 1'b1;
            wr_data.size = size_q[15:0];
            rest_d       = rdat.size - size_q[15:0] - 16'(HDR_BYTES);
            nb_d         = upper(cur_q, size_q[15:0]);
            cfree_d      = rdat.free;
            state_d      = S_SP_R;
          end else begin
            state_d = S_CF_R;
          end
        end
      end

      // Split: write the remainder block and its upper tag, then push it.
      S_SP_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(nb_q);
        state_d = S_SP_D;
      end
      S_SP_D: begin
        wr_en         = 1'b1;
        wr_data.bsize = size_q[15:0];
        wr_data.bfree = cfree_q;
        wr_data.size  = rest_q;
        wr_data.free  = 1'b1;
        lo_d          = upper(nb_q, rest_q);
        state_d       = S_SU_R;
      end
      S_SU_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(lo_q);
        state_d = S_SU_D;
      end
      S_SU_D: begin
        wr_en         = 1'b1;
        wr_data.bsize = rest_q;
        wr_data.bfree = 1'b1;
        ps_d          = slot_of(nb_q);
        ret_d         = S_CF_R;
        state_d       = S_PS_R;
      end

      // Mark the chosen block used, clear the upper neighbor's tag, then unlink it.
      S_CF_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(cur_q);
        state_d = S_CF_D;
      end
      S_CF_D: begin
        wr_en        = 1'b1;
        wr_data.free = 1'b0;
        nb_d         = upper(cur_q, rdat.size);
        state_d      = S_CU_R;
      end
      S_CU_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(nb_q);
        state_d = S_CU_D;
      end
      S_CU_D: begin
        wr_en         = 1'b1;
        wr_data.bfree = 1'b0;
        ul_d          = slot_of(cur_q);
        ret_d         = S_FIN;
        state_d       = S_UL_R;
      end

      // Unlink block ul_q from the free list.
      S_UL_R: begin
        rd_en   = 1'b1;
        rd_slot = ul_q;
        state_d = S_UL_D;
      end
      S_UL_D: begin
        un_has_d = rdat.has_next;
        un_d     = rdat.next[IDX_W-1:0];
        up_has_d = rdat.has_prev;
        upr_d    = rdat.prev[IDX_W-1:0];
        state_d  = rdat.has_next ? S_UN_R : S_UPV;
      end
      S_UN_R: begin
        rd_en   = 1'b1;
        rd_slot = un_q;
        state_d = S_UN_D;
      end
      S_UN_D: begin
        wr_en            = 1'b1;
        wr_data.has_prev = up_has_q;
        wr_data.prev     = SLOT_W'(upr_q);
        state_d          = S_UPV;
      end
      S_UPV: begin
        if (up_has_q) begin
          state_d = S_UP_R;
        end else begin
          hv_d    = un_has_q;
          head_d  = un_has_q ? un_q : '0;
          state_d = ret_q;
        end
      end
      S_UP_R: begin
        rd_en   = 1'b1;
        rd_slot = upr_q;
        state_d = S_UP_D;
      end
      S_UP_D: begin
        wr_en            = 1'b1;
        wr_data.has_next = un_has_q;
        wr_data.next     = SLOT_W'(un_q);
        state_d          = ret_q;
      end

      // Push block ps_q at the list head.
      S_PS_R: begin
        rd_en   = 1'b1;
        rd_slot = ps_q;
        state_d = S_PS_D;
      end
      S_PS_D: begin
        wr_en            = 1'b1;
        wr_data.has_next = hv_q;
        wr_data.next     = hv_q ? SLOT_W'(head_q) : '0;
        wr_data.has_prev = 1'b0;
        wr_data.prev     = '0;
        if (hv_q) begin
          state_d = S_PH_R;
        end else begin
          hv_d    = 1'b1;
          head_d  = ps_q;
          state_d = ret_q;
        end
      end
      S_PH_R: begin
        rd_en   = 1'b1;
        rd_slot = head_q;
        state_d = S_PH_D;
      end
      S_PH_D: begin
        wr_en            = 1'b1;
        wr_data.has_prev = 1'b1;
        wr_data.prev     = SLOT_W'(ps_q);
        hv_d             = 1'b1;
        head_d           = ps_q;
        state_d          = ret_q;
      end

      // Free: check the block and look at its lower tag.
      S_F0_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(cur_q);
        state_d = S_F0_D;
      end
      S_F0_D: begin
        if (rdat.free) begin
          state_d = S_FIN;
        end else begin
          nb_d = upper(cur_q, rdat.size);
          if (rdat.bfree) begin
            lo_d    = wrap(17'(cur_q) - 17'(rdat.bsize) - 17'(HDR_BYTES));
            ul_d    = slot_of(wrap(17'(cur_q) - 17'(rdat.bsize) - 17'(HDR_BYTES)));
            ret_d   = S_FL1_R;
            state_d = S_UL_R;
          end else begin
            state_d = S_FU_R;
          end
        end
      end

      // Merge with the lower neighbor.
      S_FL1_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(lo_q);
        state_d = S_FL1_D;
      end
      S_FL1_D: begin
        tmp_d   = rdat.size;
        state_d = S_FL2_R;
      end
      S_FL2_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(cur_q);
        state_d = S_FL2_D;
      end
      S_FL2_D: begin
        tmp_d   = tmp_q + rdat.size + 16'(HDR_BYTES);
        state_d = S_FL3_R;
      end
      S_FL3_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(lo_q);
        state_d = S_FL3_D;
      end
      S_FL3_D: begin
        wr_en        = 1'b1;
        wr_data.size = tmp_q;
        state_d      = S_FL4_R;
      end
      S_FL4_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(nb_q);
        state_d = S_FL4_D;
      end
      S_FL4_D: begin
        wr_en         = 1'b1;
        wr_data.bsize = tmp_q;
        wr_data.bfree = 1'b1;
        cur_d         = lo_q;
        state_d       = S_FU_R;
      end

      // Merge with the upper neighbor if it is free.
      S_FU_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(nb_q);
        state_d = S_FU_D;
      end
      S_FU_D: begin
        if (rdat.free) begin
          ul_d    = slot_of(nb_q);
          ret_d   = S_FM1_R;
          state_d = S_UL_R;
        end else begin
          state_d = S_FB_R;
        end
      end
      S_FM1_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(cur_q);
        state_d = S_FM1_D;
      end
      S_FM1_D: begin
        tmp_d   = rdat.size;
        state_d = S_FM2_R;
      end
      S_FM2_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(nb_q);
        state_d = S_FM2_D;
      end
      S_FM2_D: begin
        tmp_d   = tmp_q + rdat.size + 16'(HDR_BYTES);
        lo_d    = upper(nb_q, rdat.size);
        state_d = S_FM3_R;
      end
      S_FM3_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(cur_q);
        state_d = S_FM3_D;
      end
      S_FM3_D: begin
        wr_en        = 1'b1;
        wr_data.size = tmp_q;
        state_d      = S_FM4_R;
      end
      S_FM4_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(lo_q);
        state_d = S_FM4_D;
      end
      S_FM4_D: begin
        wr_en         = 1'b1;
        wr_data.bsize = tmp_q;
        wr_data.bfree = 1'b1;
        state_d       = S_FB_R;
      end

      // Mark the merged block free, set the upper tag, push it.
      S_FB_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(cur_q);
        state_d = S_FB_D;
      end
      S_FB_D: begin
        wr_en        = 1'b1;
        wr_data.free = 1'b1;
        nb_d         = upper(cur_q, rdat.size);
        res_ok_d     = 1'b1;
        state_d      = S_FB2_R;
      end
      S_FB2_R: begin
        rd_en   = 1'b1;
        rd_slot = slot_of(nb_q);
        state_d = S_FB2_D;
      end
      S_FB2_D: begin
        wr_en         = 1'b1;
        wr_data.bfree = 1'b1;
        ps_d          = slot_of(cur_q);
        ret_d         = S_FIN;
        state_d       = S_PS_R;
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register; it loads when the result slot is free.
  always_comb begin
    out_valid_d = out_valid_q;
    out_off_d   = out_off_q;
    out_ok_d    = out_ok_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_FIN && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      out_off_d   = res_off_q;
      out_ok_d    = res_ok_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_offset_o = out_off_q;
  assign ok_o           = out_ok_q;

  // Header memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[rd_slot_q] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_q  <= mem_q[rd_slot];
      rd_slot_q <= rd_slot;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      hv_q        <= 1'b1;
      head_q      <= '0;
      init0_q     <= 1'b1;
      initl_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      hv_q        <= hv_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      if (wr_en && rd_slot_q == '0) begin
        init0_q <= 1'b0;
      end
      if (wr_en && rd_slot_q == LAST_SLOT) begin
        initl_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    size_q    <= size_d;
    cur_q     <= cur_d;
    nb_q      <= nb_d;
    lo_q      <= lo_d;
    rest_q    <= rest_d;
    tmp_q     <= tmp_d;
    cfree_q   <= cfree_d;
    steps_q   <= steps_d;
    ul_q      <= ul_d;
    ps_q      <= ps_d;
    un_has_q  <= un_has_d;
    un_q      <= un_d;
    up_has_q  <= up_has_d;
    upr_q     <= upr_d;
    res_ok_q  <= res_ok_d;
    res_off_q <= res_off_d;
    out_off_q <= out_off_d;
    out_ok_q  <= out_ok_d;
  end

  // A write-back always follows the read of the same slot.
  a_wr_after_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> $past(rd_en))
    else $error("header write without a preceding read");

  // No header read and write in the same cycle.
  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("header read and write in the same cycle");

  // A failed result carries a zero offset.
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ok_o || block_offset_o == '0))
    else $error("failed result with nonzero offset");

  // After an accepted transfer the input side closes.
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted while busy");

endmodule
